/* src/int2a_pkg.sv */
// Shared types, format codes and ASCII constants for the integer-to-text core.
// No dependencies; used by int2a_bcd and integer_to_ascii_text_core.
package int2a_pkg;

	// Format codes carried on the func field
	localparam logic [1:0] FUNC_SDEC = 2'd0;
	localparam logic [1:0] FUNC_UDEC = 2'd1;
	localparam logic [1:0] FUNC_HEX  = 2'd2;
	localparam logic [1:0] FUNC_PTR  = 2'd3;

	localparam int FUNC_W     = 2;
	localparam int VALUE_W    = 64;
	localparam int WORD_W     = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int CHAR_W     = 8;

	// Index of the most significant digit for each format
	localparam logic [3:0] TOP_DIG_PTR = 4'd15;
	localparam logic [3:0] TOP_DIG_HEX = 4'd7;
	localparam logic [3:0] TOP_DIG_DEC = 4'd9;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2d;

	// Status of the serial binary-to-BCD converter
	typedef struct packed {
		logic busy;
		logic final_step;
	} bcd_stat_t;

	// One digit (0..15) to its lowercase ASCII character
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = CH_ZERO + {4'b0000, n};
		end else begin
			c = CH_LOWER_A - 8'd10 + {4'b0000, n};
		end
		return c;
	endfunction

endpackage

/* src/int2a_bcd.sv */
// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
// Depends on int2a_pkg.
module int2a_bcd (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [int2a_pkg::WORD_W-1:0]    bin,
	output logic [int2a_pkg::BCD_W-1:0]     bcd,
	output int2a_pkg::bcd_stat_t            stat
);

	logic [int2a_pkg::WORD_W-1:0] bin_q;
	logic [int2a_pkg::BCD_W-1:0]  bcd_q;
	logic [int2a_pkg::BCD_W-1:0]  adj;
	logic [4:0]                   cnt_q;
	logic                         busy_q;

	// Add 3 to every digit of 5 or more before the next shift
	always_comb begin
		for (int i = 0; i < int2a_pkg::BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control: 32 shift steps per conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[int2a_pkg::BCD_W-2:0], bin_q[int2a_pkg::WORD_W-1]};
			bin_q <= {bin_q[int2a_pkg::WORD_W-2:0], 1'b0};
		end
	end

	assign bcd             = bcd_q;
	assign stat.busy       = busy_q;
	assign stat.final_step = busy_q && (cnt_q == 5'd31);

endmodule

/* src/integer_to_ascii_text_core.sv */
// Integer to ASCII text: signed/unsigned decimal, hex, and 0x-prefixed pointer hex.
// Decimal items pass through the BCD converter (32 shift steps), a load of its result,
// then a digit scan that skips leading zeros and the emit of each character; hex and
// pointer hex items skip the converter. One item in flight; the next is taken the cycle
// after the last character is loaded into the output register; output stalls hold it.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops out_valid.
module integer_to_ascii_text_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [int2a_pkg::FUNC_W-1:0]      func,
	input  logic [int2a_pkg::VALUE_W-1:0]     value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [int2a_pkg::CHAR_W-1:0]      text_char,
	output logic                              last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREFIX = 3'd1;
	localparam logic [2:0] ST_CONV   = 3'd2;
	localparam logic [2:0] ST_SKIP   = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]                           state_q;
	logic [int2a_pkg::FUNC_W-1:0]         func_q;
	logic [int2a_pkg::VALUE_W-1:0]        dig_q;
	logic [3:0]                           cnt_q;
	logic                                 pre_idx_q;
	logic                                 out_valid_q;
	logic [int2a_pkg::CHAR_W-1:0]         text_char_q;
	logic                                 last_q;

	logic                                 in_xfer;
	logic                                 out_free;
	logic                                 neg;
	logic                                 is_dec;
	logic                                 hex_mode;
	logic [int2a_pkg::WORD_W-1:0]         mag32;
	logic [3:0]                           cur_nib;
	logic                                 emit;
	logic [int2a_pkg::CHAR_W-1:0]         emit_char;
	logic                                 emit_last;
	logic [int2a_pkg::BCD_W-1:0]          bcd;
	int2a_pkg::bcd_stat_t                 bcd_stat;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Magnitude of the low word; negative only in signed decimal
	assign neg    = (func == int2a_pkg::FUNC_SDEC) && value[int2a_pkg::WORD_W-1];
	assign is_dec = (func == int2a_pkg::FUNC_SDEC) || (func == int2a_pkg::FUNC_UDEC);
	assign mag32  = neg ? (~value[int2a_pkg::WORD_W-1:0] + 32'd1)
	                    : value[int2a_pkg::WORD_W-1:0];

	assign hex_mode = (func_q == int2a_pkg::FUNC_HEX) || (func_q == int2a_pkg::FUNC_PTR);
	assign cur_nib  = dig_q[{cnt_q, 2'b00} +: 4];

	int2a_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer && is_dec),
		.bin    (mag32),
		.bcd    (bcd),
		.stat   (bcd_stat)
	);

	// Character chosen for the output register this cycle
	always_comb begin
		emit      = 1'b0;
		emit_char = int2a_pkg::hex_char(cur_nib);
		emit_last = 1'b0;
		unique case (state_q)
			ST_PREFIX: begin
				emit = out_free;
				if (func_q == int2a_pkg::FUNC_PTR) begin
					emit_char = pre_idx_q ? int2a_pkg::CH_X : int2a_pkg::CH_ZERO;
				end else begin
					emit_char = int2a_pkg::CH_MINUS;
				end
			end
			ST_EMIT: begin
				emit      = out_free;
				emit_last = (cnt_q == 4'd0);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			func_q    <= int2a_pkg::FUNC_SDEC;
			cnt_q     <= '0;
			pre_idx_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						func_q    <= func;
						pre_idx_q <= 1'b0;
						if (func == int2a_pkg::FUNC_PTR) begin
							cnt_q <= int2a_pkg::TOP_DIG_PTR;
						end else if (func == int2a_pkg::FUNC_HEX) begin
							cnt_q <= int2a_pkg::TOP_DIG_HEX;
						end else begin
							cnt_q <= int2a_pkg::TOP_DIG_DEC;
						end
						if (neg || (func == int2a_pkg::FUNC_PTR)) begin
							state_q <= ST_PREFIX;
						end else if (is_dec) begin
							state_q <= ST_CONV;
						end else begin
							state_q <= ST_SKIP;
						end
					end
				end
				ST_PREFIX: begin
					if (out_free) begin
						if (func_q == int2a_pkg::FUNC_PTR && !pre_idx_q) begin
							pre_idx_q <= 1'b1;
						end else begin
							state_q <= hex_mode ? ST_SKIP : ST_CONV;
						end
					end
				end
				ST_CONV: begin
					if (!bcd_stat.busy) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (cur_nib == 4'd0 && cnt_q != 4'd0) begin
						cnt_q <= cnt_q - 4'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (cnt_q == 4'd0) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - 4'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit store: raw nibbles for hex, BCD result for decimal
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (func == int2a_pkg::FUNC_PTR) begin
				dig_q <= value;
			end else begin
				dig_q <= {{(int2a_pkg::VALUE_W-int2a_pkg::WORD_W){1'b0}},
				          value[int2a_pkg::WORD_W-1:0]};
			end
		end else if (state_q == ST_CONV && !bcd_stat.busy) begin
			dig_q <= {{(int2a_pkg::VALUE_W-int2a_pkg::BCD_W){1'b0}}, bcd};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			text_char_q <= emit_char;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last      = last_q;

	// Checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after an input transfer");

	a_bcd_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_stat.busy |-> (state_q == ST_PREFIX || state_q == ST_CONV))
		else $error("BCD converter running outside prefix/conversion");

	a_bcd_finish: assert property (@(posedge clk) disable iff (!arst_n)
		bcd_stat.final_step |=> !bcd_stat.busy)
		else $error("BCD converter did not stop after its last step");

	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !hex_mode) |-> (cur_nib < 4'd10))
		else $error("decimal digit out of range");

endmodule
